// ----- rtl/edt_pkg.sv -----
// ----------------------------------------------------------------------------
// edt_pkg
// Shared types, widths and codes of the earliest deadline event timer.
// ----------------------------------------------------------------------------
package edt_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int TIME_WIDTH = 48;

    // fixed field widths of the channels
    localparam int FUNC_W       = 2;
    localparam int IDX_FIELD_W  = 3;
    localparam int FIELD_TIME_W = 48;
    localparam int CFG_W        = 17;
    localparam int COUNT_W      = 16;

    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LEVELS    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PAD_SLOTS = 1 << LEVELS;
    localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_W-1:0] DIVIDE_RESET = 17'd1;
    localparam logic [CFG_W-1:0] DIVIDE_MAX   = 17'd65536;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_TICK,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_W-1:0]     slot;
        logic [TIME_WIDTH-1:0] due;
        logic                  arm;
    } cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [SLOT_W-1:0]     idx;
        logic [TIME_WIDTH-1:0] due;
    } cand_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    // lower half wins ties, which keeps the lowest slot index on equal times
    function automatic cand_t cand_better(cand_t lo, cand_t hi);
        cand_t res;
        if (lo.valid && (!hi.valid || lo.due <= hi.due)) begin
            res = lo;
        end else begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// ----- rtl/edt_front.sv -----
// ----------------------------------------------------------------------------
// edt_front
// Input side: accepts items, decodes the function code and queues commands.
// ----------------------------------------------------------------------------
module edt_front import edt_pkg::*; (
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FUNC_W-1:0]       s_func,
    input  logic [IDX_FIELD_W-1:0]  s_slot_index,
    input  logic [FIELD_TIME_W-1:0] s_event_time,
    input  logic                    s_event_ready,
    output logic                    push_valid,
    input  logic                    push_ready,
    output cmd_t                    push_cmd
);

    logic [31:0] idx_ext;
    logic [63:0] time_ext;
    op_t         op;

    assign idx_ext  = 32'(s_slot_index);
    assign time_ext = 64'(s_event_time);

    always_comb begin
        case (s_func)
            FUNC_TICK:  op = OP_TICK;
            FUNC_WRITE: op = (idx_ext < 32'(NUM_SLOTS)) ? OP_WRITE : OP_NOP;
            FUNC_READ:  op = OP_READ;
            default:    op = OP_NOP;
        endcase
    end

    assign push_cmd.op   = op;
    assign push_cmd.slot = idx_ext[SLOT_W-1:0];
    assign push_cmd.due  = time_ext[TIME_WIDTH-1:0];
    assign push_cmd.arm  = s_event_ready;

    // drop items that do nothing; they still complete the transfer
    assign s_ready    = push_ready && aresetn;
    assign push_valid = s_valid && aresetn && (op != OP_NOP);

endmodule

// ----- rtl/edt_fifo.sv -----
// ----------------------------------------------------------------------------
// edt_fifo
// Short command queue between the decode side and the execution side.
// ----------------------------------------------------------------------------
module edt_fifo import edt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/edt_back.sv -----
// ----------------------------------------------------------------------------
// edt_back
// Execution side: time base, prescaler, event slots, earliest deadline
// search over registered reduction levels, and the result register.
// ----------------------------------------------------------------------------
module edt_back import edt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  cmd_t                    pop_cmd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_result_kind,
    output logic [IDX_FIELD_W-1:0]  m_fired_slot,
    output logic [FIELD_TIME_W-1:0] m_time_value
);

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      divide_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] due_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  armed_reg;
    cand_t                 cand_reg [PAD_SLOTS];
    cand_t                 cand_load [PAD_SLOTS];
    cand_t                 cand_red [PAD_SLOTS];
    logic [LEVEL_W-1:0]    level_reg;

    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [IDX_FIELD_W-1:0]  out_slot_reg;
    logic [FIELD_TIME_W-1:0] out_time_reg;

    logic             out_free;
    logic             do_pop, do_tick, do_write, load_read, load_fire;
    logic [CFG_W-1:0] divide_eff;
    logic [CFG_W-1:0] count_inc;
    logic             last_level;
    logic [31:0]      fire_idx_ext;
    logic [63:0]      time_ext;

    assign cfg_ready = aresetn;
    assign out_free  = !out_valid_reg || m_ready;
    assign last_level = (level_reg == LEVEL_W'(LEVELS - 1));

    always_comb begin
        if (divide_reg == '0) begin
            divide_eff = 17'd1;
        end else if (divide_reg > DIVIDE_MAX) begin
            divide_eff = DIVIDE_MAX;
        end else begin
            divide_eff = divide_reg;
        end
    end

    assign count_inc = {1'b0, count_reg} + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid && pop_cmd.op == OP_TICK) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_REDUCE;
            ST_REDUCE: begin
                if (last_level) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!cand_reg[0].valid || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop_ready = 1'b0;
        load_fire = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // a read waits until the result register can take it
                pop_ready = (pop_cmd.op != OP_READ) || out_free;
            end
            ST_EMIT: begin
                load_fire = cand_reg[0].valid && out_free;
            end
            default: begin
                pop_ready = 1'b0;
                load_fire = 1'b0;
            end
        endcase
    end

    assign do_pop    = pop_valid && pop_ready;
    assign do_tick   = do_pop && (pop_cmd.op == OP_TICK);
    assign do_write  = do_pop && (pop_cmd.op == OP_WRITE);
    assign load_read = do_pop && (pop_cmd.op == OP_READ);

    // candidates: armed and already due, compared against the advanced time
    always_comb begin
        for (int i = 0; i < PAD_SLOTS; i++) begin
            if (i < NUM_SLOTS) begin
                cand_load[i].valid = armed_reg[i] && (due_reg[i] <= time_reg);
                cand_load[i].due   = due_reg[i];
            end else begin
                cand_load[i].valid = 1'b0;
                cand_load[i].due   = '0;
            end
            cand_load[i].idx = SLOT_W'(i);
        end
    end

    // one tree level per cycle, pairs fold into the lower half in place
    always_comb begin
        for (int i = 0; i < PAD_SLOTS; i++) begin
            cand_red[i] = cand_reg[i];
        end
        for (int i = 0; i < PAD_SLOTS / 2; i++) begin
            cand_red[i] = cand_better(cand_reg[2 * i], cand_reg[2 * i + 1]);
        end
    end

    assign fire_idx_ext = 32'(cand_reg[0].idx);
    assign time_ext     = 64'(time_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            divide_reg    <= DIVIDE_RESET;
            count_reg     <= '0;
            time_reg      <= '0;
            armed_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                divide_reg <= cfg_data;
            end
            if (do_tick) begin
                if (count_inc >= divide_eff) begin
                    count_reg <= '0;
                    time_reg  <= time_reg + 1'b1;
                end else begin
                    count_reg <= count_inc[COUNT_W-1:0];
                end
            end
            if (do_write) begin
                armed_reg[pop_cmd.slot] <= pop_cmd.arm;
            end
            if (load_fire) begin
                armed_reg[cand_reg[0].idx] <= 1'b0;
            end
            if (state_reg == ST_REDUCE) begin
                level_reg <= last_level ? '0 : level_reg + 1'b1;
            end
            if (load_read || load_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            due_reg[pop_cmd.slot] <= pop_cmd.due;
        end
        if (state_reg == ST_LOAD) begin
            cand_reg <= cand_load;
        end else if (state_reg == ST_REDUCE) begin
            cand_reg <= cand_red;
        end
        if (load_read) begin
            out_kind_reg <= KIND_READ;
            out_slot_reg <= '0;
            out_time_reg <= time_ext[FIELD_TIME_W-1:0];
        end else if (load_fire) begin
            out_kind_reg <= KIND_EVENT;
            out_slot_reg <= fire_idx_ext[IDX_FIELD_W-1:0];
            out_time_reg <= '0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_fired_slot  = out_slot_reg;
    assign m_time_value  = out_time_reg;

endmodule

// ----- rtl/earliest_deadline_event_timer_top.sv -----
// ----------------------------------------------------------------------------
// earliest_deadline_event_timer_top
// Prescaled 48-bit time base with eight event slots, earliest deadline first.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries items: func 0 ticks the prescaler, func 1 loads a slot's due
//   time and armed flag, func 2 reads the time base. func 3 and writes to a
//   slot beyond the last are accepted and dropped.
//   m_* returns results: an event fired (slot index) or a time read.
//   cfg_* writes prescale_divide; write it only while the block is idle.
// Command flow:
//   An accepted item sits in a two-entry command queue; a read result then
//   goes through the result register to m_valid. A write or read executes
//   without leaving idle. A tick steps through advance, compare all slots
//   against the time, one registered reduction level per cycle, then fire;
//   no command is taken meanwhile. The search tree sets the tick rate.
// Reset:
//   Time base, prescaler and armed flags clear, prescale_divide returns to 1,
//   the queue empties. Due times are not cleared.
// Stall:
//   The result register holds while m_ready is low; the queue keeps taking
//   items until it is full, then s_ready drops.
// ----------------------------------------------------------------------------
module earliest_deadline_event_timer_top import edt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [FUNC_W-1:0]       s_func,
    input  logic [IDX_FIELD_W-1:0]  s_slot_index,
    input  logic [FIELD_TIME_W-1:0] s_event_time,
    input  logic                    s_event_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_result_kind,
    output logic [IDX_FIELD_W-1:0]  m_fired_slot,
    output logic [FIELD_TIME_W-1:0] m_time_value
);

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    edt_front u_front (
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slot_index  (s_slot_index),
        .s_event_time  (s_event_time),
        .s_event_ready (s_event_ready),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    edt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    edt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_fired_slot  (m_fired_slot),
        .m_time_value  (m_time_value)
    );

endmodule

// ----- rtl/edt_checker.sv -----
// ----------------------------------------------------------------------------
// edt_checker
// Port-level checks on the event timer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module edt_checker import edt_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_result_kind,
    input logic [IDX_FIELD_W-1:0]  m_fired_slot,
    input logic [FIELD_TIME_W-1:0] m_time_value
);

    // no result may be pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    a_read_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_READ) |-> (m_fired_slot == '0))
        else $error("time read result carries a slot index");

    a_event_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_EVENT) |-> (m_time_value == '0))
        else $error("event result carries a time value");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_kind)
            && $stable(m_fired_slot) && $stable(m_time_value)))
        else $error("stalled result changed");

endmodule

bind earliest_deadline_event_timer_top edt_checker u_edt_checker (.*);
